@@ rtl/core/keyed_dense_table_swap_remove_defines.svh @@
// ---------------------------------------------------------------------------
// keyed dense table assertion macros
// shared property shorthands, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef KEYED_DENSE_TABLE_SWAP_REMOVE_DEFINES_SVH
`define KEYED_DENSE_TABLE_SWAP_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KDTSR_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define KDTSR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`else

`define KDTSR_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define KDTSR_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ rtl/core/kdtsr_pkg.sv @@
// ---------------------------------------------------------------------------
// kdtsr_pkg
// sizes, codes and shared types of the keyed dense table
// ---------------------------------------------------------------------------
package kdtsr_pkg;

    // table geometry
    localparam int CAPACITY     = 1024;
    localparam int KEY_BITS     = 12;
    localparam int PAYLOAD_BITS = 64;
    localparam int KEY_SPACE    = 1 << KEY_BITS;
    localparam int SLOT_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);

    // item field widths and positions
    localparam int OP_W         = 2;
    localparam int KEY_IN_W     = 12;
    localparam int PAYLOAD_IN_W = 64;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 11;
    localparam int OP_LSB       = 0;
    localparam int KEY_LSB      = OP_LSB + OP_W;
    localparam int PAYLOAD_LSB  = KEY_LSB + KEY_IN_W;
    localparam int S_FIELDS_W   = PAYLOAD_LSB + PAYLOAD_IN_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W   = STATUS_W + 1 + PAYLOAD_IN_W + COUNT_OUT_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_HAS    = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // index map entry: presence and slot of one key
    typedef struct packed {
        logic                 valid;
        logic [SLOT_BITS-1:0] slot;
    } t_map_entry;

    // index map write request
    typedef struct packed {
        logic                we;
        logic [KEY_BITS-1:0] addr;
        t_map_entry          data;
    } t_map_wr;

    // slot store write request
    typedef struct packed {
        logic                    we;
        logic [SLOT_BITS-1:0]    addr;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot_wr;

    // one result item
    typedef struct packed {
        logic [COUNT_OUT_W-1:0]  count;
        logic [PAYLOAD_IN_W-1:0] payload;
        logic                    existed;
        t_status                 status;
    } t_result;

endpackage

@@ rtl/core/keyed_dense_table_swap_remove.sv @@
// ---------------------------------------------------------------------------
// keyed_dense_table_swap_remove
// keyed table packed in slots 0..count-1, index map by key, swap-remove
// ---------------------------------------------------------------------------
//  channel   dir  bits  fields (lsb first)
//  s (in)    in   80    op[1:0], entry_key[13:2], payload_in[77:14]
//  m (out)   out  80    status[1:0], existed[2], payload_out[66:3], live_count[77:67]
//
//  update, get and has pass lookup and access; a hit remove adds unmap (index map read,
//  slot read, moved-entry write, unmap of the removed key on the single map write port).
//  one item is worked at a time; the next is taken once the result has been
//  loaded into the output register and the holding register is empty.
//  after reset the index map is swept clear over all 2^KEY_BITS (4096) keys with
//  s ready held low.
//  a stalled output holds one finished result and one more in a holding register.
// ---------------------------------------------------------------------------
`include "keyed_dense_table_swap_remove_defines.svh"

module keyed_dense_table_swap_remove (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // op, entry_key, payload_in, zero pad
    input  logic [kdtsr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, existed, payload_out, live_count, zero pad
    output logic [kdtsr_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_ACCESS = 4'b0100,
        ST_UNMAP  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    kdtsr_pkg::t_op                       r_op;
    logic [kdtsr_pkg::KEY_BITS-1:0]       r_key;
    logic [kdtsr_pkg::PAYLOAD_BITS-1:0]   r_data;
    logic                                 r_present;
    logic [kdtsr_pkg::SLOT_BITS-1:0]      r_slot;
    logic [kdtsr_pkg::COUNT_BITS-1:0]     r_count, n_count;
    logic                                 r_out_valid;
    kdtsr_pkg::t_result                   r_out;
    logic                                 r_pend;
    kdtsr_pkg::t_result                   r_pend_res;

    logic                                 s_fire;
    logic                                 out_free;
    logic                                 done;
    logic                                 full;
    logic                                 present_c;
    logic [kdtsr_pkg::SLOT_BITS-1:0]      last_slot;
    kdtsr_pkg::t_result                   res_c;

    kdtsr_pkg::t_map_entry                map_rd;
    kdtsr_pkg::t_map_wr                   map_wr;
    logic                                 clr_busy;
    logic                                 slot_re;
    logic [kdtsr_pkg::SLOT_BITS-1:0]      slot_raddr;
    kdtsr_pkg::t_slot_wr                  slot_wr;
    logic [kdtsr_pkg::KEY_BITS-1:0]       slot_rd_key;
    logic [kdtsr_pkg::PAYLOAD_BITS-1:0]   slot_rd_payload;

    logic                                 count_ok;
    logic                                 in_unmap;
    logic                                 remove_hit;
    logic                                 out_err;

    // handshake
    assign o_s_tready = (r_state == ST_IDLE) && !r_pend && !clr_busy;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // memories
    kdtsr_index_map u_index_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_fire),
        .i_rd_addr  (kdtsr_pkg::KEY_BITS'(i_s_tdata[kdtsr_pkg::KEY_LSB +: kdtsr_pkg::KEY_IN_W])),
        .i_wr       (map_wr),
        .o_rd_data  (map_rd),
        .o_clr_busy (clr_busy)
    );

    kdtsr_slot_store u_slot_store (
        .i_clk        (i_clk),
        .i_rd_en      (slot_re),
        .i_rd_addr    (slot_raddr),
        .i_wr         (slot_wr),
        .o_rd_key     (slot_rd_key),
        .o_rd_payload (slot_rd_payload)
    );

    // lookup decode: a map entry counts only if it points below the count
    assign full      = (r_count == kdtsr_pkg::COUNT_BITS'(kdtsr_pkg::CAPACITY));
    assign last_slot = kdtsr_pkg::SLOT_BITS'(r_count - 1'b1);
    assign present_c = map_rd.valid && (kdtsr_pkg::COUNT_BITS'(map_rd.slot) < r_count);
    assign slot_re   = (r_state == ST_LOOKUP);
    assign slot_raddr = (r_op == kdtsr_pkg::OP_REMOVE) ? last_slot : map_rd.slot;

    // operation sequencer, memory writes and result
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        done          = 1'b0;
        map_wr        = '0;
        slot_wr       = '0;
        res_c         = '0;
        res_c.status  = kdtsr_pkg::ST_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_ACCESS;
            end
            ST_ACCESS: begin
                n_state = ST_IDLE;
                done    = 1'b1;
                unique case (r_op)
                    kdtsr_pkg::OP_UPDATE: begin
                        if (r_present) begin
                            slot_wr       = '{we: 1'b1, addr: r_slot, key: r_key,
                                              payload: r_data};
                            res_c.existed = 1'b1;
                        end else if (full) begin
                            res_c.status  = kdtsr_pkg::ST_FULL;
                        end else begin
                            slot_wr = '{we: 1'b1,
                                        addr: kdtsr_pkg::SLOT_BITS'(r_count),
                                        key: r_key, payload: r_data};
                            map_wr  = '{we: 1'b1, addr: r_key,
                                        data: '{valid: 1'b1,
                                                slot: kdtsr_pkg::SLOT_BITS'(r_count)}};
                            n_count = r_count + 1'b1;
                        end
                    end
                    kdtsr_pkg::OP_REMOVE: begin
                        if (!r_present) begin
                            res_c.status = kdtsr_pkg::ST_NOT_FOUND;
                        end else begin
                            // move the last entry into the freed slot
                            done    = 1'b0;
                            n_state = ST_UNMAP;
                            if (r_slot != last_slot) begin
                                slot_wr = '{we: 1'b1, addr: r_slot, key: slot_rd_key,
                                            payload: slot_rd_payload};
                                map_wr  = '{we: 1'b1, addr: slot_rd_key,
                                            data: '{valid: 1'b1, slot: r_slot}};
                            end
                        end
                    end
                    kdtsr_pkg::OP_GET: begin
                        if (r_present) begin
                            res_c.existed = 1'b1;
                            res_c.payload = kdtsr_pkg::PAYLOAD_IN_W'(slot_rd_payload);
                        end else begin
                            res_c.status  = kdtsr_pkg::ST_NOT_FOUND;
                        end
                    end
                    kdtsr_pkg::OP_HAS: begin
                        if (r_present) begin
                            res_c.existed = 1'b1;
                        end else begin
                            res_c.status  = kdtsr_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        res_c.status = kdtsr_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            ST_UNMAP: begin
                // final map write of a remove: drop the removed key
                n_state       = ST_IDLE;
                done          = 1'b1;
                map_wr        = '{we: 1'b1, addr: r_key, data: '0};
                n_count       = r_count - 1'b1;
                res_c.existed = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        res_c.count = kdtsr_pkg::COUNT_OUT_W'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // item capture and lookup result
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op   <= kdtsr_pkg::t_op'(i_s_tdata[kdtsr_pkg::OP_LSB +: kdtsr_pkg::OP_W]);
            r_key  <= kdtsr_pkg::KEY_BITS'(i_s_tdata[kdtsr_pkg::KEY_LSB +: kdtsr_pkg::KEY_IN_W]);
            r_data <= kdtsr_pkg::PAYLOAD_BITS'(
                          i_s_tdata[kdtsr_pkg::PAYLOAD_LSB +: kdtsr_pkg::PAYLOAD_IN_W]);
        end
        if (r_state == ST_LOOKUP) begin
            r_present <= present_c;
            r_slot    <= map_rd.slot;
        end
    end

    // output register with one holding register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (done) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_pend      <= 1'b1;
            end
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
            r_pend      <= 1'b0;
        end else if (r_out_valid && i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            if (out_free) begin
                r_out <= res_c;
            end else begin
                r_pend_res <= res_c;
            end
        end else if (r_pend && out_free) begin
            r_out <= r_pend_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{kdtsr_pkg::M_PAD_W{1'b0}}, r_out.count, r_out.payload,
                         r_out.existed, r_out.status};

    // terms for the checks below
    assign count_ok   = (r_count <= kdtsr_pkg::COUNT_BITS'(kdtsr_pkg::CAPACITY));
    assign in_unmap   = (r_state == ST_UNMAP);
    assign remove_hit = (r_op == kdtsr_pkg::OP_REMOVE) && r_present;
    assign out_err    = r_out_valid && (r_out.status != kdtsr_pkg::ST_OK);

    `KDTSR_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, count_ok)
    `KDTSR_ASSERT_NEXT(a_accept_to_lookup, i_clk, i_rst_n, s_fire, r_state == ST_LOOKUP)
    `KDTSR_ASSERT_IMPLY(a_unmap_after_remove, i_clk, i_rst_n, in_unmap, $past(r_state) == ST_ACCESS && remove_hit)
    `KDTSR_ASSERT_NEXT(a_unmap_shrinks, i_clk, i_rst_n, in_unmap, r_count == $past(r_count) - 1'b1)
    `KDTSR_ASSERT_IMPLY(a_payload_only_ok, i_clk, i_rst_n, out_err, r_out.payload == '0)

endmodule

@@ rtl/core/kdtsr_index_map.sv @@
// ---------------------------------------------------------------------------
// kdtsr_index_map
// key-addressed map of valid bit and slot, with a clearing sweep after reset
// ---------------------------------------------------------------------------
`include "keyed_dense_table_swap_remove_defines.svh"

module kdtsr_index_map (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [kdtsr_pkg::KEY_BITS-1:0]   i_rd_addr,
    input  kdtsr_pkg::t_map_wr               i_wr,
    output kdtsr_pkg::t_map_entry            o_rd_data,
    output logic                             o_clr_busy
);

    kdtsr_pkg::t_map_entry mem [kdtsr_pkg::KEY_SPACE];
    kdtsr_pkg::t_map_entry r_rd;

    logic                           r_clr_busy;
    logic [kdtsr_pkg::KEY_BITS-1:0] r_clr_addr;

    // sweep every key to invalid, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // single write port, sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd;
    assign o_clr_busy = r_clr_busy;

    `KDTSR_ASSERT_IMPLY(a_no_wr_in_clear, i_clk, i_rst_n, r_clr_busy, !i_wr.we && !i_rd_en)
    `KDTSR_ASSERT_IMPLY(a_clear_ends_at_top, i_clk, i_rst_n, $fell(r_clr_busy), $past(r_clr_addr) == '1)
    `KDTSR_ASSERT_NEXT(a_clear_steps, i_clk, i_rst_n, r_clr_busy && (r_clr_addr != '1), r_clr_busy)

endmodule

@@ rtl/core/kdtsr_slot_store.sv @@
// ---------------------------------------------------------------------------
// kdtsr_slot_store
// packed slot memory holding key and payload of each live entry
// ---------------------------------------------------------------------------
module kdtsr_slot_store (
    input  logic                               i_clk,
    input  logic                               i_rd_en,
    input  logic [kdtsr_pkg::SLOT_BITS-1:0]    i_rd_addr,
    input  kdtsr_pkg::t_slot_wr                i_wr,
    output logic [kdtsr_pkg::KEY_BITS-1:0]     o_rd_key,
    output logic [kdtsr_pkg::PAYLOAD_BITS-1:0] o_rd_payload
);

    localparam int EntryW = kdtsr_pkg::KEY_BITS + kdtsr_pkg::PAYLOAD_BITS;

    logic [EntryW-1:0] mem [kdtsr_pkg::CAPACITY];
    logic [EntryW-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= {i_wr.key, i_wr.payload};
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_key     = r_rd[EntryW-1 -: kdtsr_pkg::KEY_BITS];
    assign o_rd_payload = r_rd[kdtsr_pkg::PAYLOAD_BITS-1:0];

endmodule

@@ sim/keyed_dense_table_swap_remove_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keyed_dense_table_swap_remove_tb
// drives update, remove, get and has items into the keyed dense table over the
// s channel and checks every result on the m channel against a mirror of the
// table kept in the bench: directed corner items first, then random phases
// that fill the table to capacity and then remove heavily, under varying back-pressure
// ---------------------------------------------------------------------------
module keyed_dense_table_swap_remove_tb;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_STEPS     = 24;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    // op, entry_key, payload_in, zero pad
    logic [kdtsr_pkg::S_TDATA_W-1:0]  i_s_tdata;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    // status, existed, payload_out, live_count, zero pad
    logic [kdtsr_pkg::M_TDATA_W-1:0]  o_m_tdata;

    keyed_dense_table_swap_remove u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // mirror of the table contents
    logic [kdtsr_pkg::KEY_BITS-1:0]     mirror_key     [kdtsr_pkg::CAPACITY];
    logic [kdtsr_pkg::PAYLOAD_BITS-1:0] mirror_payload [kdtsr_pkg::CAPACITY];
    logic                               mirror_valid   [kdtsr_pkg::KEY_SPACE];
    logic [kdtsr_pkg::SLOT_BITS-1:0]    mirror_slot    [kdtsr_pkg::KEY_SPACE];
    logic [kdtsr_pkg::COUNT_BITS-1:0]   mirror_count;

    kdtsr_pkg::t_result expected_results [$];

    int fail_count    = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold_left  = 0;
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;

    // directed items, expectation typed in where it is obvious
    typedef struct {
        kdtsr_pkg::t_op                     op;
        logic [kdtsr_pkg::KEY_BITS-1:0]     key;
        logic [kdtsr_pkg::PAYLOAD_BITS-1:0] data;
        bit                                 typed;
        kdtsr_pkg::t_status                 st;
        logic                               existed;
        logic [kdtsr_pkg::PAYLOAD_BITS-1:0] payload;
        logic [kdtsr_pkg::COUNT_OUT_W-1:0]  count;
    } t_step_row;

    t_step_row directed_steps [N_STEPS] = '{
        '{kdtsr_pkg::OP_GET,    12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_HAS,    12'hfff, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_REMOVE, 12'hfff, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_UPDATE, 12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd1},
        '{kdtsr_pkg::OP_UPDATE, 12'hfff, 64'hffff_ffff_ffff_ffff,
          1'b1, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd2},
        '{kdtsr_pkg::OP_GET,    12'hfff, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'hffff_ffff_ffff_ffff, 11'd2},
        '{kdtsr_pkg::OP_GET,    12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd2},
        '{kdtsr_pkg::OP_HAS,    12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd2},
        '{kdtsr_pkg::OP_UPDATE, 12'h000, 64'ha5a5_a5a5_a5a5_a5a5,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd2},
        '{kdtsr_pkg::OP_GET,    12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'ha5a5_a5a5_a5a5_a5a5, 11'd2},
        '{kdtsr_pkg::OP_UPDATE, 12'h555, 64'h5555_5555_5555_5555,
          1'b1, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd3},
        '{kdtsr_pkg::OP_UPDATE, 12'haaa, 64'haaaa_aaaa_aaaa_aaaa,
          1'b1, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd4},
        '{kdtsr_pkg::OP_REMOVE, 12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd3},
        '{kdtsr_pkg::OP_GET,    12'haaa, 64'h0,
          1'b0, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_HAS,    12'h000, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd3},
        '{kdtsr_pkg::OP_REMOVE, 12'haaa, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd2},
        '{kdtsr_pkg::OP_GET,    12'h555, 64'h0,
          1'b0, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_REMOVE, 12'h555, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd1},
        '{kdtsr_pkg::OP_GET,    12'hfff, 64'h0,
          1'b0, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_REMOVE, 12'hfff, 64'h0,
          1'b1, kdtsr_pkg::ST_OK, 1'b1, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_REMOVE, 12'hfff, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_UPDATE, 12'h123, 64'h0123_4567_89ab_cdef,
          1'b1, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd1},
        '{kdtsr_pkg::OP_GET,    12'h123, 64'h0,
          1'b0, kdtsr_pkg::ST_OK, 1'b0, 64'h0, 11'd0},
        '{kdtsr_pkg::OP_HAS,    12'hffe, 64'h0,
          1'b1, kdtsr_pkg::ST_NOT_FOUND, 1'b0, 64'h0, 11'd1}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // apply one item to the mirror and return the result it must produce
    function automatic kdtsr_pkg::t_result table_apply(
        kdtsr_pkg::t_op op, logic [kdtsr_pkg::KEY_BITS-1:0] key,
        logic [kdtsr_pkg::PAYLOAD_BITS-1:0] data);
        kdtsr_pkg::t_result              r;
        logic                            present;
        logic [kdtsr_pkg::SLOT_BITS-1:0] slot;
        logic [kdtsr_pkg::SLOT_BITS-1:0] last_slot;
        logic [kdtsr_pkg::KEY_BITS-1:0]  moved;
        r        = '0;
        r.status = kdtsr_pkg::ST_OK;
        present  = mirror_valid[key];
        slot     = present ? mirror_slot[key] : '0;
        if (present && slot >= mirror_count) present = 1'b0;
        if (op == kdtsr_pkg::OP_UPDATE) begin
            if (present) begin
                mirror_key[slot]     = key;
                mirror_payload[slot] = data;
                r.existed            = 1'b1;
            end else if (mirror_count >= kdtsr_pkg::CAPACITY) begin
                r.status = kdtsr_pkg::ST_FULL;
            end else begin
                slot                 = mirror_count[kdtsr_pkg::SLOT_BITS-1:0];
                mirror_key[slot]     = key;
                mirror_payload[slot] = data;
                mirror_slot[key]     = slot;
                mirror_valid[key]    = 1'b1;
                mirror_count         = mirror_count + 1'b1;
            end
        end else if (!present) begin
            r.status = kdtsr_pkg::ST_NOT_FOUND;
        end else begin
            r.existed = 1'b1;
            case (op)
                kdtsr_pkg::OP_REMOVE: begin
                    last_slot = kdtsr_pkg::SLOT_BITS'(mirror_count - 1'b1);
                    // last entry fills the hole
                    if (slot != last_slot) begin
                        moved                = mirror_key[last_slot];
                        mirror_key[slot]     = moved;
                        mirror_payload[slot] = mirror_payload[last_slot];
                        mirror_slot[moved]   = slot;
                    end
                    mirror_valid[key] = 1'b0;
                    mirror_count      = mirror_count - 1'b1;
                end
                kdtsr_pkg::OP_GET: r.payload = mirror_payload[slot];
                default: ;
            endcase
        end
        r.count = kdtsr_pkg::COUNT_OUT_W'(mirror_count);
        return r;
    endfunction

    // offer one item, wait for the handshake, then predict
    task automatic send_item(input kdtsr_pkg::t_op op,
                             input logic [kdtsr_pkg::KEY_BITS-1:0] key,
                             input logic [kdtsr_pkg::PAYLOAD_BITS-1:0] data,
                             output kdtsr_pkg::t_result pred);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(4, 1);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(kdtsr_pkg::S_TDATA_W - kdtsr_pkg::S_FIELDS_W){1'b0}}, data, key, op};
        do @(posedge i_clk); while (!o_s_tready);
        pred = table_apply(op, key, data);
    endtask

    // queue one expected result behind the others
    task automatic expect_add(input kdtsr_pkg::t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic issue(input kdtsr_pkg::t_op op,
                         input logic [kdtsr_pkg::KEY_BITS-1:0] key,
                         input logic [kdtsr_pkg::PAYLOAD_BITS-1:0] data);
        kdtsr_pkg::t_result r;
        send_item(op, key, data, r);
        expect_add(r);
    endtask

    function automatic logic [kdtsr_pkg::PAYLOAD_BITS-1:0] random_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present key half the time, else a spread pool or any key
    function automatic logic [kdtsr_pkg::KEY_BITS-1:0] pick_key();
        if (mirror_count != 0 && $urandom_range(1) == 1)
            return mirror_key[$urandom_range(int'(mirror_count) - 1)];
        if ($urandom_range(1) == 1)
            return kdtsr_pkg::KEY_BITS'($urandom_range(31) * 127);
        return kdtsr_pkg::KEY_BITS'($urandom_range(kdtsr_pkg::KEY_SPACE - 1));
    endfunction

    function automatic logic [kdtsr_pkg::KEY_BITS-1:0] absent_key();
        logic [kdtsr_pkg::KEY_BITS-1:0] k;
        do k = kdtsr_pkg::KEY_BITS'($urandom_range(kdtsr_pkg::KEY_SPACE - 1));
        while (mirror_valid[k]);
        return k;
    endfunction

    task automatic random_mix(input int n, input int upd_pct, input int rem_pct,
                              input int get_pct);
        int roll;
        kdtsr_pkg::t_op op;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < upd_pct)                          op = kdtsr_pkg::OP_UPDATE;
            else if (roll < upd_pct + rem_pct)           op = kdtsr_pkg::OP_REMOVE;
            else if (roll < upd_pct + rem_pct + get_pct) op = kdtsr_pkg::OP_GET;
            else                                         op = kdtsr_pkg::OP_HAS;
            issue(op, pick_key(), random_payload());
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // receiver: check accepted results, then choose next ready
    always @(posedge i_clk) begin : rx_side
        kdtsr_pkg::t_result got;
        kdtsr_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = kdtsr_pkg::t_result'(o_m_tdata[kdtsr_pkg::M_FIELDS_W-1:0]);
            if (expected_results.size() == 0) begin
                $error("result item with no item outstanding: %h", o_m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.existed !== want.existed) begin
                    $error("existed: expected %0d, got %0d", want.existed, got.existed);
                    fail_count++;
                end
                if (got.payload !== want.payload) begin
                    $error("payload_out: expected %h, got %h", want.payload, got.payload);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("live_count: expected %0d, got %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
        if (hold_request) begin
            rx_hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("keyed_dense_table_swap_remove_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin : stimulus
        kdtsr_pkg::t_result r;
        int                 n_fill;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        mirror_count = '0;
        for (int k = 0; k < kdtsr_pkg::KEY_SPACE; k++) begin
            mirror_valid[k] = 1'b0;
            mirror_slot[k]  = '0;
        end
        for (int s = 0; s < kdtsr_pkg::CAPACITY; s++) begin
            mirror_key[s]     = '0;
            mirror_payload[s] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        set_idling(0, 0);
        foreach (directed_steps[i]) begin
            send_item(directed_steps[i].op, directed_steps[i].key, directed_steps[i].data, r);
            if (directed_steps[i].typed) begin
                r.status  = directed_steps[i].st;
                r.existed = directed_steps[i].existed;
                r.payload = directed_steps[i].payload;
                r.count   = directed_steps[i].count;
            end
            expect_add(r);
        end

        // mixed traffic on a small table
        random_mix(80, 35, 20, 25);
        set_idling(67, 0);
        random_mix(60, 35, 20, 25);

        // long output hold while items keep coming
        set_idling(0, 67);
        hold_request = 1'b1;
        random_mix(60, 35, 20, 25);

        // fill to capacity, idling changes as it goes
        n_fill = 0;
        while (mirror_count < kdtsr_pkg::CAPACITY) begin
            case ((n_fill / 250) % 4)
                0: set_idling(0, 0);
                1: set_idling(33, 33);
                2: set_idling(67, 0);
                default: set_idling(0, 67);
            endcase
            if ($urandom_range(9) != 0 || mirror_count == 0)
                issue(kdtsr_pkg::OP_UPDATE,
                      kdtsr_pkg::KEY_BITS'($urandom_range(kdtsr_pkg::KEY_SPACE - 1)),
                      random_payload());
            else
                issue($urandom_range(1) ? kdtsr_pkg::OP_GET : kdtsr_pkg::OP_HAS,
                      mirror_key[$urandom_range(int'(mirror_count) - 1)], random_payload());
            n_fill++;
        end

        // full table: rejected inserts, overwrites, remove then refill
        set_idling(33, 33);
        for (int i = 0; i < 8; i++) begin
            issue(kdtsr_pkg::OP_UPDATE, absent_key(), random_payload());
            issue(kdtsr_pkg::OP_UPDATE, mirror_key[$urandom_range(kdtsr_pkg::CAPACITY - 1)],
                  random_payload());
            issue(kdtsr_pkg::OP_GET, mirror_key[$urandom_range(kdtsr_pkg::CAPACITY - 1)], '0);
        end
        for (int i = 0; i < 5; i++) begin
            issue(kdtsr_pkg::OP_REMOVE, mirror_key[$urandom_range(kdtsr_pkg::CAPACITY - 1)],
                  random_payload());
            issue(kdtsr_pkg::OP_UPDATE, absent_key(), random_payload());
            issue(kdtsr_pkg::OP_UPDATE, absent_key(), random_payload());
        end

        // drain-heavy traffic
        set_idling(67, 67);
        random_mix(60, 15, 55, 15);

        i_s_tvalid <= 1'b0;
        set_idling(0, 0);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("keyed_dense_table_swap_remove_tb passed");
        else
            $display("keyed_dense_table_swap_remove_tb failed");
        $finish;
    end

endmodule
